// ===== rtl/twu_pkg.sv =====
// twu_pkg: shared constants, types and digit helpers for the ternary weight unpacker
// no dependencies; used by the stream interfaces and the top level

package twu_pkg;

    localparam int TRITS_PER_BYTE = 5;
    localparam int COUNT_WIDTH    = 24;
    localparam int BYTE_W         = 8;
    localparam int MAX_TRITS      = 5;
    localparam int K_W            = $clog2(TRITS_PER_BYTE + 1);
    localparam int POW_W          = 10;

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] ADDR_TENSOR_TRITS = '0;

    typedef logic [K_W-1:0]          t_trit_cnt;
    typedef logic [1:0]              t_trit;
    typedef t_trit [MAX_TRITS-1:0]   t_trits;
    typedef logic signed [1:0]       t_weight;
    typedef logic [COUNT_WIDTH-1:0]  t_count;

    typedef struct packed {
        t_weight weight;
        logic    bad_digit;
        logic    last_of_byte;
        logic    last_of_tensor;
    } t_result;

    function automatic logic [POW_W-1:0] pow3(input int e);
        logic [POW_W-1:0] p;
        case (e)
            0:       p = 10'd1;
            1:       p = 10'd3;
            2:       p = 10'd9;
            3:       p = 10'd27;
            4:       p = 10'd81;
            5:       p = 10'd243;
            default: p = 10'd0;
        endcase
        return p;
    endfunction

    // base-3 digits of a byte, lowest position first; the top digit may read 3
    function automatic t_trits trit_digits(input logic [BYTE_W-1:0] b);
        logic [POW_W-1:0] r;
        logic [POW_W-1:0] p1;
        logic [POW_W-1:0] p2;
        logic [POW_W-1:0] p3;
        t_trits           d;
        r = {{(POW_W-BYTE_W){1'b0}}, b};
        d = '0;
        for (int i = MAX_TRITS - 1; i >= 0; i--) begin
            p1 = pow3(i);
            p2 = {p1[POW_W-2:0], 1'b0};
            p3 = p2 + p1;
            if (r >= p3) begin
                d[i] = 2'd3;
                r    = r - p3;
            end else if (r >= p2) begin
                d[i] = 2'd2;
                r    = r - p2;
            end else if (r >= p1) begin
                d[i] = 2'd1;
                r    = r - p1;
            end else begin
                d[i] = 2'd0;
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/twu_if.sv =====
// twu_in_if / twu_out_if: valid/ready stream interfaces for packed bytes and weights
// depends on twu_pkg

interface twu_in_if;
    logic                         valid;
    logic                         ready;
    logic [twu_pkg::BYTE_W-1:0]   packed_byte;
    logic                         last_byte;

    modport source (output valid, output packed_byte, output last_byte, input ready);
    modport sink   (input valid, input packed_byte, input last_byte, output ready);
endinterface

interface twu_out_if;
    logic                 valid;
    logic                 ready;
    twu_pkg::t_weight     weight;
    logic                 bad_digit;
    logic                 last_of_byte;
    logic                 last_of_tensor;

    modport source (output valid, output weight, output bad_digit, output last_of_byte,
                    output last_of_tensor, input ready);
    modport sink   (input valid, input weight, input bad_digit, input last_of_byte,
                    input last_of_tensor, output ready);
endinterface

// ===== rtl/ternary_weight_unpacker_unit.sv =====
// ternary_weight_unpacker_unit: base-3 byte unpacker, up to five weights per byte
// depends on twu_pkg and the stream interfaces in twu_if.sv
// path: a byte passes from the input register through the unpack register to the output register
// throughput: one weight per cycle on the output while the receiver is ready; a byte yielding k weights
// holds the unpack register until its last weight moves on, a byte yielding none is dropped without loading it
// reset: synchronous, active low; clears all valids, the weight count and tensor_trits

module ternary_weight_unpacker_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    twu_in_if.sink                        i_in,
    twu_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twu_pkg::PADDR_W-1:0]   paddr,
    input  logic [twu_pkg::PDATA_W-1:0]   pwdata,
    output logic [twu_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import twu_pkg::*;

    // configuration
    t_count r_tensor_trits;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // unpack register
    logic      r_w_valid;
    t_trits    r_w_digits;
    t_trit_cnt r_w_pos;
    logic      r_w_first;
    logic      r_w_bad_lead;
    logic      r_w_tensor_end;

    // output register
    logic    r_o_valid;
    t_result r_o_data;

    t_count r_count;

    logic      active;
    t_count    owed;
    t_trit_cnt k;
    logic      ends_tensor;
    logic      a_take;
    logic      w_load;
    logic      w_fire;
    logic      w_done;
    logic      w_free;
    logic      out_free;
    t_trit     cur_digit;
    logic      cur_bad;
    t_result   n_o_data;
    t_count    n_count;

    // apb
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_TENSOR_TRITS) begin
            prdata = PDATA_W'(r_tensor_trits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tensor_trits <= '0;
        end else if (psel && penable && pwrite && paddr == ADDR_TENSOR_TRITS) begin
            r_tensor_trits <= pwdata[COUNT_WIDTH-1:0];
        end
    end

    // weights owed for the byte in the input register
    always_comb begin
        active      = r_count < r_tensor_trits;
        owed        = r_tensor_trits - r_count;
        ends_tensor = owed <= COUNT_WIDTH'(TRITS_PER_BYTE);
        if (!active) begin
            k = '0;
        end else if (ends_tensor) begin
            k = owed[K_W-1:0];
        end else begin
            k = K_W'(TRITS_PER_BYTE);
        end
    end

    assign out_free = !r_o_valid || o_out.ready;
    assign w_fire   = r_w_valid && out_free;
    assign w_done   = w_fire && (r_w_pos == '0);
    assign w_free   = !r_w_valid || w_done;
    assign a_take   = r_in_valid && ((k == '0) || w_free);
    assign w_load   = a_take && (k != '0);

    assign i_in.ready = !r_in_valid || a_take;

    always_comb begin
        if (r_in_last) begin
            n_count = '0;
        end else begin
            n_count = r_count + COUNT_WIDTH'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_count    <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (a_take) begin
                r_in_valid <= 1'b0;
            end
            if (a_take) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.packed_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // unpack register: one digit per cycle while the output register is free, most significant first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else if (w_load) begin
            r_w_valid <= 1'b1;
        end else if (w_done) begin
            r_w_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_w_digits     <= trit_digits(r_in_byte);
            r_w_pos        <= k - t_trit_cnt'(1);
            r_w_first      <= 1'b1;
            r_w_bad_lead   <= {{(POW_W-BYTE_W){1'b0}}, r_in_byte} >= pow3(int'(k));
            r_w_tensor_end <= ends_tensor;
        end else if (w_fire) begin
            r_w_pos   <= r_w_pos - t_trit_cnt'(1);
            r_w_first <= 1'b0;
        end
    end

    always_comb begin
        cur_digit = r_w_digits[r_w_pos];
        cur_bad   = r_w_first && r_w_bad_lead;
        n_o_data.bad_digit      = cur_bad;
        n_o_data.weight         = cur_bad ? t_weight'(2'd0) : t_weight'(cur_digit + 2'd3);
        n_o_data.last_of_byte   = r_w_pos == '0;
        n_o_data.last_of_tensor = (r_w_pos == '0) && r_w_tensor_end;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_fire) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.weight         = r_o_data.weight;
    assign o_out.bad_digit      = r_o_data.bad_digit;
    assign o_out.last_of_byte   = r_o_data.last_of_byte;
    assign o_out.last_of_tensor = r_o_data.last_of_tensor;

endmodule

// ===== verif/tb_ternary_weight_unpacker_unit.sv =====
// tb_ternary_weight_unpacker_unit: self-checking bench for the base-3 weight unpacker
// depends on twu_pkg, twu_in_if/twu_out_if and ternary_weight_unpacker_unit
// predicts every weight from each accepted byte and checks each output transfer in order

module tb_ternary_weight_unpacker_unit;
    import twu_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_PRINTS   = 100;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_byte_item;

    typedef enum logic [1:0] {RCV_OPEN, RCV_COIN, RCV_MOSTLY, RCV_SLOW} t_rcv_mode;

    class weight_checker;
        t_result pending_weights[$];
        t_count  weights_done;
        t_count  tensor_len;
        int      errors;

        function new();
            weights_done = '0;
            tensor_len   = '0;
            errors       = 0;
        endfunction

        function void set_tensor(t_count len);
            tensor_len = len;
        endfunction

        function int pending_count();
            return pending_weights.size();
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // digits read most significant first over k positions
        function void note_byte(logic [BYTE_W-1:0] b, logic last);
            int unsigned rem;
            int unsigned owed;
            int unsigned k;
            int unsigned p;
            int unsigned digit;
            t_result     r;
            rem = b;
            if (weights_done < tensor_len) begin
                owed = tensor_len - weights_done;
                k = (owed < TRITS_PER_BYTE) ? owed : TRITS_PER_BYTE;
                for (int j = 0; j < k; j++) begin
                    p = 1;
                    for (int e = 0; e < k - 1 - j; e++)
                        p = p * 3;
                    digit = rem / p;
                    rem   = rem % p;
                    r.bad_digit      = (digit > 2);
                    r.weight         = r.bad_digit ? t_weight'(0) : t_weight'(digit - 1);
                    weights_done     = weights_done + 1'b1;
                    r.last_of_byte   = (j == k - 1);
                    r.last_of_tensor = (weights_done == tensor_len);
                    pending_weights  = {pending_weights, r};
                end
            end
            if (last)
                weights_done = '0;
        endfunction

        task check_weight(t_result got);
            t_result want;
            if (pending_weights.size() == 0) begin
                report($sformatf("weight %0d with none expected", got.weight));
                return;
            end
            want = pending_weights.pop_front();
            if (got.weight !== want.weight)
                report($sformatf("weight %0d, want %0d", got.weight, want.weight));
            if (got.bad_digit !== want.bad_digit)
                report($sformatf("bad_digit %b, want %b", got.bad_digit, want.bad_digit));
            if (got.last_of_byte !== want.last_of_byte)
                report($sformatf("last_of_byte %b, want %b",
                                 got.last_of_byte, want.last_of_byte));
            if (got.last_of_tensor !== want.last_of_tensor)
                report($sformatf("last_of_tensor %b, want %b",
                                 got.last_of_tensor, want.last_of_tensor));
        endtask

        task check_leftovers();
            if (pending_weights.size() != 0)
                report($sformatf("%0d weights never arrived", pending_weights.size()));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    twu_in_if  in_if ();
    twu_out_if out_if ();

    ternary_weight_unpacker_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    weight_checker chk = new();

    t_byte_item  stim_q[$];
    int          burst_left = 0;
    int          idle_cycles = 0;
    int unsigned rcv_tick = 0;
    t_rcv_mode   rcv_mode = RCV_OPEN;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // byte and weight transfers
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            chk.note_byte(in_if.packed_byte, in_if.last_byte);
        if (i_rst_n && out_if.valid && out_if.ready)
            chk.check_weight(t_result'{out_if.weight, out_if.bad_digit,
                                       out_if.last_of_byte, out_if.last_of_tensor});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // receiver stall pattern in one of four modes, redrawn at random periodically
    always @(negedge i_clk) begin
        rcv_tick++;
        if (rcv_tick % 32 == 0)
            rcv_mode = t_rcv_mode'($urandom_range(0, 3));
        case (rcv_mode)
            RCV_OPEN:   out_if.ready = 1'b1;
            RCV_COIN:   out_if.ready = 1'($urandom_range(0, 1));
            RCV_MOSTLY: out_if.ready = ($urandom_range(0, 3) != 0);
            default:    out_if.ready = 1'(rcv_tick >> 3);
        endcase
    end

    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 9) == 0)
            return BYTE_W'($urandom_range(243, 255));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic push_byte(logic [BYTE_W-1:0] b, logic last);
        stim_q = {stim_q, t_byte_item'{b, last}};
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_bytes();
        t_byte_item it;
        int         gap;
        while (stim_q.size() > 0) begin
            it = stim_q.pop_front();
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 4);
                if (gap > 0) begin
                    in_if.valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, 10);
            end
            in_if.valid       = 1'b1;
            in_if.packed_byte = it.data;
            in_if.last_byte   = it.last;
            do @(posedge i_clk); while (!in_if.ready);
            burst_left--;
            @(negedge i_clk);
        end
        in_if.valid = 1'b0;
    endtask

    task automatic write_tensor_trits(logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_TENSOR_TRITS;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        chk.set_tensor(value[COUNT_WIDTH-1:0]);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_idle();
        while (chk.pending_count() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // mostly whole tensors ending in a last byte, some cut short, unterminated or padded
    task automatic random_tensors(t_count len, int n_items);
        int made;
        int nbytes;
        int shape;
        int extra;
        made = 0;
        while (made < n_items) begin
            nbytes = (len > 60) ? $urandom_range(1, 8) : (len + 4) / 5;
            if (nbytes == 0)
                nbytes = 1;
            shape = $urandom_range(0, 9);
            if (shape == 0)
                nbytes = $urandom_range(1, nbytes);
            extra = (shape == 2) ? $urandom_range(1, 3) : 0;
            for (int i = 0; i < nbytes; i++)
                push_byte(pick_byte(), (i == nbytes - 1) && shape != 1 && extra == 0);
            for (int i = 0; i < extra; i++)
                push_byte(pick_byte(), i == extra - 1);
            made += nbytes;
        end
        send_bytes();
        wait_idle();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_if.valid       = 1'b0;
        in_if.packed_byte = '0;
        in_if.last_byte   = 1'b0;
        out_if.ready      = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero-length tensor yields nothing
        push_byte(8'd5, 1'b0);
        push_byte(8'd255, 1'b1);
        send_bytes();
        wait_idle();

        // all -1, all +1, bad leading digit, short byte, bytes past the end, restart
        write_tensor_trits(32'd12);
        push_byte(8'd0, 1'b0);
        push_byte(8'd242, 1'b0);
        push_byte(8'd243, 1'b0);
        push_byte(8'd121, 1'b0);
        push_byte(8'd77, 1'b0);
        push_byte(8'd8, 1'b1);
        push_byte(8'd255, 1'b0);
        push_byte(8'd128, 1'b1);
        send_bytes();
        wait_idle();

        // one-trit tensor, last byte clears after an empty byte
        write_tensor_trits(32'd1);
        push_byte(8'd2, 1'b0);
        push_byte(8'd3, 1'b1);
        push_byte(8'd1, 1'b0);
        push_byte(8'd0, 1'b1);
        send_bytes();
        wait_idle();

        // largest tensor, upper data bits ignored
        write_tensor_trits(32'hA5FF_FFFF);
        push_byte(8'd255, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'd170, 1'b0);
        push_byte(8'd85, 1'b1);
        send_bytes();
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            t_count len;
            case (ph)
                0:       len = t_count'($urandom_range(1, 30));
                1:       len = '1;
                2:       len = t_count'($urandom_range(1, 4));
                3:       len = t_count'($urandom_range(6, 60));
                4:       len = t_count'(TRITS_PER_BYTE);
                default: len = t_count'($urandom_range(1, 30));
            endcase
            write_tensor_trits({8'($urandom_range(0, 255)), len});
            random_tensors(len, 14);
        end

        chk.check_leftovers();
        if (chk.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
